// ----- rtl/q2m_pkg.sv -----
// ----------------------------------------------------------------------------
// q2m_pkg: shared types and helpers for the quaternion to rotation matrix block
// Holds the fixed-point constants and the truncating 4.12 product helper.
// ----------------------------------------------------------------------------
package q2m_pkg;

   localparam int QuatWidth  = 16;
   localparam int WordWidth  = 32;
   localparam int FracBits   = 12;
   localparam int SumWidth   = 32;
   localparam int DivStages  = 26;   // quotient bits needed: numerator is 2^25
   localparam logic signed [WordWidth-1:0] OneFx    = 32'sh0000_1000;
   localparam logic [SumWidth-1:0]         ScaleNum = 32'h0200_0000;

   typedef logic signed [WordWidth-1:0] word_type;

   // 32x32 product wrapped to 32 bits, then divided by 0x1000 toward zero
   function automatic word_type fx_mul(input word_type a, input word_type b);
      logic signed [63:0] full;
      word_type           p;
      word_type           adj;
      full = a * b;
      p    = full[WordWidth-1:0];
      adj  = p[WordWidth-1] ? (p + word_type'((1 << FracBits) - 1)) : p;
      return adj >>> FracBits;
   endfunction

endpackage

// ----- rtl/q2m_div.sv -----
// ----------------------------------------------------------------------------
// q2m_div: pipelined restoring divider
// Computes ScaleNum / divisor one quotient bit per stage, carrying a tag.
// ----------------------------------------------------------------------------
module q2m_div #(
   parameter int TagWidth = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              advance,
   input  logic                              in_valid,
   input  logic [q2m_pkg::SumWidth-1:0]      in_divisor,
   input  logic [TagWidth-1:0]               in_tag,
   output logic                              out_valid,
   output logic [q2m_pkg::SumWidth-1:0]      out_quot,
   output logic [TagWidth-1:0]               out_tag
);
   import q2m_pkg::*;

   localparam int N = DivStages;

   logic                  vld_ff [N];
   logic [SumWidth-1:0]   den_ff [N];
   logic [SumWidth:0]     rem_ff [N];
   logic [N-1:0]          quo_ff [N];
   logic [TagWidth-1:0]   tag_ff [N];

   for (genvar i = 0; i < N; i++) begin : g_stage
      logic                vld_cur;
      logic [SumWidth-1:0] den_cur;
      logic [SumWidth:0]   rem_cur;
      logic [N-1:0]        quo_cur;
      logic [TagWidth-1:0] tag_cur;
      logic [SumWidth:0]   trial_in;
      logic                bit_in;

      if (i == 0) begin : g_head
         assign vld_cur = in_valid;
         assign den_cur = in_divisor;
         assign rem_cur = '0;
         assign quo_cur = '0;
         assign tag_cur = in_tag;
      end else begin : g_link
         assign vld_cur = vld_ff[i-1];
         assign den_cur = den_ff[i-1];
         assign rem_cur = rem_ff[i-1];
         assign quo_cur = quo_ff[i-1];
         assign tag_cur = tag_ff[i-1];
      end

      always_comb begin
         trial_in = {rem_cur[SumWidth-1:0], ScaleNum[N-1-i]};
         bit_in   = trial_in >= {1'b0, den_cur};
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else if (advance) begin
            vld_ff[i] <= vld_cur;
         end
         if (advance) begin
            den_ff[i] <= den_cur;
            rem_ff[i] <= bit_in ? trial_in - {1'b0, den_cur} : trial_in;
            quo_ff[i] <= {quo_cur[N-2:0], bit_in};
            tag_ff[i] <= tag_cur;
         end
      end
   end

   assign out_valid = vld_ff[N-1];
   assign out_quot  = SumWidth'(quo_ff[N-1]);
   assign out_tag   = tag_ff[N-1];

endmodule

// ----- rtl/q2m_front.sv -----
// ----------------------------------------------------------------------------
// q2m_front: squares and norm sum
// Two register stages: squared parts, then the wrapped norm sum.
// ----------------------------------------------------------------------------
module q2m_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        advance,
   input  logic                        in_valid,
   input  logic [4*q2m_pkg::QuatWidth-1:0] in_quat,
   output logic                        out_valid,
   output logic [q2m_pkg::SumWidth-1:0] out_sum,
   output logic [4*q2m_pkg::QuatWidth-1:0] out_quat
);
   import q2m_pkg::*;

   logic     s1_vld_ff;
   word_type sq_ff [4];
   word_type sq_in [4];
   logic [4*QuatWidth-1:0] s1_quat_ff;
   logic     s2_vld_ff;
   logic [SumWidth-1:0] sum_ff;
   logic [4*QuatWidth-1:0] s2_quat_ff;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         sq_in[i] = fx_mul(word_type'($signed(in_quat[i*QuatWidth +: QuatWidth])),
                           word_type'($signed(in_quat[i*QuatWidth +: QuatWidth])));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
      end else if (advance) begin
         s1_vld_ff <= in_valid;
         s2_vld_ff <= s1_vld_ff;
      end
      if (advance) begin
         sq_ff      <= sq_in;
         s1_quat_ff <= in_quat;
         sum_ff     <= SumWidth'((sq_ff[0] + sq_ff[1]) + (sq_ff[2] + sq_ff[3]));
         s2_quat_ff <= s1_quat_ff;
      end
   end

   assign out_valid = s2_vld_ff;
   assign out_sum   = sum_ff;
   assign out_quat  = s2_quat_ff;

endmodule

// ----- rtl/q2m_back.sv -----
// ----------------------------------------------------------------------------
// q2m_back: scaled parts, pair products and matrix entries
// Three register stages after the scale is known.
// ----------------------------------------------------------------------------
module q2m_back (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            advance,
   input  logic                            in_valid,
   input  logic [q2m_pkg::SumWidth-1:0]    in_scale,
   input  logic                            in_zero,
   input  logic [4*q2m_pkg::QuatWidth-1:0] in_quat,
   output logic                            out_valid,
   output logic [9*q2m_pkg::WordWidth:0]   out_data
);
   import q2m_pkg::*;

   logic     v1_ff, v2_ff, v3_ff;
   word_type a1_ff, b1_ff, c1_ff, w1_ff, sa_ff, sb_ff, sc_ff;
   logic     z1_ff, z2_ff, z3_ff;
   word_type aa_ff, ab_ff, ac_ff, bb_ff, bc_ff, cc_ff, wa_ff, wb_ff, wc_ff;
   word_type m_ff [9];
   word_type a0, b0, c0, w0, s0;

   always_comb begin
      a0 = word_type'($signed(in_quat[0*QuatWidth +: QuatWidth]));
      b0 = word_type'($signed(in_quat[1*QuatWidth +: QuatWidth]));
      c0 = word_type'($signed(in_quat[2*QuatWidth +: QuatWidth]));
      w0 = word_type'($signed(in_quat[3*QuatWidth +: QuatWidth]));
      s0 = in_zero ? '0 : word_type'(in_scale);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
      if (advance) begin
         a1_ff <= a0;
         b1_ff <= b0;
         c1_ff <= c0;
         w1_ff <= w0;
         sa_ff <= fx_mul(a0, s0);
         sb_ff <= fx_mul(b0, s0);
         sc_ff <= fx_mul(c0, s0);
         z1_ff <= in_zero;
         aa_ff <= fx_mul(a1_ff, sa_ff);
         ab_ff <= fx_mul(a1_ff, sb_ff);
         ac_ff <= fx_mul(a1_ff, sc_ff);
         bb_ff <= fx_mul(b1_ff, sb_ff);
         bc_ff <= fx_mul(b1_ff, sc_ff);
         cc_ff <= fx_mul(c1_ff, sc_ff);
         wa_ff <= fx_mul(w1_ff, sa_ff);
         wb_ff <= fx_mul(w1_ff, sb_ff);
         wc_ff <= fx_mul(w1_ff, sc_ff);
         z2_ff <= z1_ff;
         m_ff[0] <= OneFx - (bb_ff + cc_ff);
         m_ff[1] <= ab_ff + wc_ff;
         m_ff[2] <= ac_ff - wb_ff;
         m_ff[3] <= ab_ff - wc_ff;
         m_ff[4] <= OneFx - (cc_ff + aa_ff);
         m_ff[5] <= bc_ff + wa_ff;
         m_ff[6] <= ac_ff + wb_ff;
         m_ff[7] <= bc_ff - wa_ff;
         m_ff[8] <= OneFx - (aa_ff + bb_ff);
         z3_ff <= z2_ff;
      end
   end

   assign out_valid = v3_ff;
   assign out_data  = {z3_ff, m_ff[8], m_ff[7], m_ff[6], m_ff[5], m_ff[4],
                       m_ff[3], m_ff[2], m_ff[1], m_ff[0]};

endmodule

// ----- rtl/quaternion_to_rotation_matrix.sv -----
// ----------------------------------------------------------------------------
// quaternion_to_rotation_matrix: 4.12 quaternion to 3x3 rotation block
// Pipelined norm, scale divider and product stages behind a skid buffer.
// ----------------------------------------------------------------------------
//  channel | direction | tdata fields (low bit up)             | tuser
//  req     | in        | quat_a, quat_b, quat_c, quat_w (64b)   | -
//  rsp     | out       | m_r0c0 .. m_r2c2 (288b)                | zero_norm
//
// 32 register stages from req to rsp: 2 norm stages, 26 divider stages (one
// quotient bit each), 3 product stages and the output register. Synchronous
// reset clears all valid bits. One transaction per cycle unless stalled.
// The pipeline advances whenever the skid stage is empty; a stall holds every
// stage, and the skid register keeps the transaction already on its way.
module quaternion_to_rotation_matrix (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [63:0]  req_tdata,   // quat_a, quat_b, quat_c, quat_w
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [287:0] rsp_tdata,   // m_r0c0, m_r0c1, ..., m_r2c2
   output logic         rsp_tuser    // zero_norm
);
   import q2m_pkg::*;

   localparam int QW = 4 * QuatWidth;
   localparam int OW = 9 * WordWidth + 1;

   logic          advance;
   logic          f_vld, d_vld, b_vld;
   logic [SumWidth-1:0] f_sum, d_quot;
   logic [QW-1:0] f_quat;
   logic [QW:0]   d_tag;
   logic [OW-1:0] b_data;
   logic          out_vld_ff, skid_vld_ff;
   logic [OW-1:0] out_data_ff, skid_data_ff;

   // advance while the skid stage is empty
   assign advance    = !skid_vld_ff;
   assign req_tready = advance;

   q2m_front u_front (
      .clock, .reset, .advance,
      .in_valid (req_tvalid && advance),
      .in_quat  (req_tdata),
      .out_valid(f_vld),
      .out_sum  (f_sum),
      .out_quat (f_quat)
   );

   q2m_div #(.TagWidth(QW + 1)) u_div (
      .clock, .reset, .advance,
      .in_valid  (f_vld),
      .in_divisor(f_sum),
      .in_tag    ({f_sum == '0, f_quat}),
      .out_valid (d_vld),
      .out_quot  (d_quot),
      .out_tag   (d_tag)
   );

   q2m_back u_back (
      .clock, .reset, .advance,
      .in_valid (d_vld),
      .in_scale (d_quot),
      .in_zero  (d_tag[QW]),
      .in_quat  (d_tag[QW-1:0]),
      .out_valid(b_vld),
      .out_data (b_data)
   );

   // output register plus skid stage
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         if (!out_vld_ff || rsp_tready) begin
            out_vld_ff  <= skid_vld_ff || (advance && b_vld);
            skid_vld_ff <= 1'b0;
         end else if (advance && b_vld) begin
            skid_vld_ff <= 1'b1;
         end
      end
      if (!out_vld_ff || rsp_tready) begin
         out_data_ff <= skid_vld_ff ? skid_data_ff : b_data;
      end else if (advance && b_vld) begin
         skid_data_ff <= b_data;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_data_ff[OW-2:0];
   assign rsp_tuser  = out_data_ff[OW-1];

endmodule

// ----- tb/sv/quaternion_to_rotation_matrix_test.sv -----
// ----------------------------------------------------------------------------
// quaternion_to_rotation_matrix_test: self-checking bench for the 4.12 block
// Drives quaternions on the request stream, predicts each rotation matrix and
// compares every response field in order, under several idling phases.
// ----------------------------------------------------------------------------
module quaternion_to_rotation_matrix_test;
   import q2m_pkg::*;

   localparam int PipeDepth   = 32;
   localparam int IdleLimit   = 20000;
   localparam int RandomItems = 1750;

   typedef struct {
      logic signed [31:0] entry [9];
      logic               zero_norm;
   } rot_matrix_type;

   class rotation_scoreboard;
      rot_matrix_type pending[$];
      int             errors;

      // truncating 4.12 product, 32-bit wrap
      static function logic signed [31:0] fxp(logic signed [31:0] x, logic signed [31:0] y);
         logic signed [63:0] full;
         logic signed [31:0] p;
         full = x * y;
         p    = full[31:0];
         return p / 32'sd4096;
      endfunction

      function void note_quaternion(logic [63:0] packed_q);
         logic signed [31:0] a, b, c, w, sum, s, sa, sb, sc;
         logic signed [31:0] wa, wb, wc, aa, ab, ac, bb, bc, cc;
         rot_matrix_type m;
         a = $signed(packed_q[15:0]);
         b = $signed(packed_q[31:16]);
         c = $signed(packed_q[47:32]);
         w = $signed(packed_q[63:48]);
         sum = fxp(a, a) + fxp(b, b) + (fxp(c, c) + fxp(w, w));
         m.zero_norm = (sum == 0);
         s  = m.zero_norm ? 32'sd0 : 32'sh0200_0000 / sum;
         sa = fxp(a, s); sb = fxp(b, s); sc = fxp(c, s);
         wa = fxp(w, sa); wb = fxp(w, sb); wc = fxp(w, sc);
         aa = fxp(a, sa); ab = fxp(a, sb); ac = fxp(a, sc);
         bb = fxp(b, sb); bc = fxp(b, sc); cc = fxp(c, sc);
         m.entry[0] = 32'sh1000 - (bb + cc);
         m.entry[1] = ab + wc;
         m.entry[2] = ac - wb;
         m.entry[3] = ab - wc;
         m.entry[4] = 32'sh1000 - (cc + aa);
         m.entry[5] = bc + wa;
         m.entry[6] = ac + wb;
         m.entry[7] = bc - wa;
         m.entry[8] = 32'sh1000 - (aa + bb);
         pending.push_back(m);
      endfunction

      function void check_matrix(logic [287:0] data, logic flag);
         rot_matrix_type m;
         logic [31:0] got;
         if (pending.size() == 0) begin
            $error("unexpected response transaction");
            errors++;
            return;
         end
         m = pending.pop_front();
         for (int i = 0; i < 9; i++) begin
            got = data[32*i +: 32];
            if (got !== m.entry[i]) begin
               $error("m_r%0dc%0d: expected %h, got %h", i / 3, i % 3, m.entry[i], got);
               errors++;
            end
         end
         if (flag !== m.zero_norm) begin
            $error("zero_norm: expected %b, got %b", m.zero_norm, flag);
            errors++;
         end
      endfunction
   endclass

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [63:0]  req_tdata;   // quat_a, quat_b, quat_c, quat_w
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [287:0] rsp_tdata;   // m_r0c0, m_r0c1, ..., m_r2c2
   logic         rsp_tuser;   // zero_norm

   rotation_scoreboard matrices = new();
   int send_idle_pct;
   int recv_stall_pct;
   int quiet_cycles;
   bit stimulus_done;

   quaternion_to_rotation_matrix dut (.*);

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // response side: stall, check, watchdog
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready   <= 1'b0;
         quiet_cycles <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready)
            matrices.check_matrix(rsp_tdata, rsp_tuser);
         if ((rsp_tvalid && rsp_tready) || (req_tvalid && req_tready))
            quiet_cycles <= 0;
         else if (matrices.pending.size() != 0 || !stimulus_done)
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= IdleLimit) begin
            $display("CHECKS FAILED");
            $finish;
         end
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // leaves tvalid high after the accepting edge; the caller drops it
   task automatic send_quaternion(logic [15:0] a, logic [15:0] b,
                                  logic [15:0] c, logic [15:0] w);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {w, c, b, a};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      matrices.note_quaternion(req_tdata);
   endtask

   function automatic logic [15:0] pick_part();
      case ($urandom_range(5))
         0: return 16'h1000 + 16'($urandom_range(64)) - 16'd32;
         1: return 16'hF000 + 16'($urandom_range(64)) - 16'd32;
         2: return 16'($urandom_range(255)) - 16'd128;
         3: return {$urandom_range(1) ? 2'b11 : 2'b00, 14'($urandom)};
         default: return 16'($urandom);
      endcase
   endfunction

   initial begin
      int idle_plan [4][2] = '{'{0, 0}, '{70, 0}, '{0, 70}, '{7, 7}};
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      stimulus_done = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: zero norm, identity, unit axes, extremes, tiny norms
      send_quaternion(16'h0000, 16'h0000, 16'h0000, 16'h0000);
      send_quaternion(16'h0000, 16'h0000, 16'h0000, 16'h1000);
      send_quaternion(16'h1000, 16'h0000, 16'h0000, 16'h0000);
      send_quaternion(16'h0000, 16'h1000, 16'h0000, 16'h0000);
      send_quaternion(16'h0000, 16'h0000, 16'hF000, 16'h0000);
      send_quaternion(16'h0800, 16'h0800, 16'h0800, 16'h0800);
      send_quaternion(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
      send_quaternion(16'h8000, 16'h8000, 16'h8000, 16'h8000);
      send_quaternion(16'h7FFF, 16'h8000, 16'h0000, 16'h7FFF);
      send_quaternion(16'h0001, 16'hFFFF, 16'h0001, 16'hFFFF);
      send_quaternion(16'h0040, 16'h0000, 16'h0000, 16'h0000);
      send_quaternion(16'h0041, 16'h0000, 16'h0000, 16'h0000);
      send_quaternion(16'h0000, 16'h0000, 16'h0000, 16'hFFC0);
      send_quaternion(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA);
      send_quaternion(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555);
      send_quaternion(16'h0B50, 16'hF4B0, 16'h0000, 16'h0B50);

      for (int ph = 0; ph < 8; ph++) begin
         send_idle_pct  = idle_plan[ph % 4][0];
         recv_stall_pct = idle_plan[ph % 4][1];
         for (int i = 0; i < RandomItems / 8; i++)
            send_quaternion(pick_part(), pick_part(), pick_part(), pick_part());
      end
      req_tvalid <= 1'b0;
      stimulus_done = 1'b1;

      while (matrices.pending.size() != 0) @(posedge clock);
      repeat (PipeDepth + 10) @(posedge clock);
      if (matrices.errors == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
